>>> rtl/core/trs_pkg.sv
`default_nettype none
package trs_pkg;

    localparam int TIMER_DEPTH = 16;
    localparam int READY_DEPTH = 16;
    localparam int TASK_BITS   = 6;
    localparam int TIME_BITS   = 32;
    localparam int LEVEL_BITS  = 5;
    localparam int TIMER_AW    = $clog2(TIMER_DEPTH);
    localparam int READY_AW    = $clog2(READY_DEPTH);
    localparam int TENTRY_BITS = TIME_BITS + TASK_BITS;

    typedef enum logic [1:0] {
        OP_ADD_READY = 2'd0,
        OP_ADD_TIMER = 2'd1,
        OP_CHECK     = 2'd2,
        OP_DEQUEUE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NONE  = 3'd1,
        ST_FULL  = 3'd2,
        ST_DUP   = 3'd3,
        ST_FIN   = 3'd4,
        ST_MOVED = 3'd5,
        ST_XDROP = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_CHK,
        S_CHK,
        S_LOADF,
        S_SCAN,
        S_DEQ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]           operation;
        logic [TASK_BITS-1:0] task_id;
        logic [TIME_BITS-1:0] due_time;
        logic [TIME_BITS-1:0] now;
        logic                 finished;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [TASK_BITS-1:0]  result_task;
        logic [LEVEL_BITS-1:0] ready_level;
        logic [LEVEL_BITS-1:0] timer_level;
        logic [TIME_BITS-1:0]  next_wake;
        logic                  last;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/core/trs_if.sv
`default_nettype none
interface trs_in_if;
    logic               valid;
    logic               ready;
    trs_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trs_out_if;
    logic               valid;
    logic               ready;
    trs_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/trs_ram.sv
`default_nettype none
module trs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/timer_and_ready_scheduler_core.sv
`default_nettype none
// An add ready walks the ready queue for a duplicate; an add timer moves later timers up
// one entry at a time before it writes the new one; a dequeue reads the ready head; a check
// moves each expired timer into the ready queue with one result each, or gives one none.
// One transaction is handled at a time; the walks over the memories, each with one read
// and one write port, set its length. A new transaction is accepted while the previous
// result waits in the output register. Synchronous active-low reset empties both stores.
module timer_and_ready_scheduler_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    trs_in_if.sink     i_req,
    trs_out_if.source  o_rsp
);

    trs_pkg::t_state                     r_state, n_state;
    logic [trs_pkg::TASK_BITS-1:0]       r_task, n_task;
    logic [trs_pkg::TIME_BITS-1:0]       r_wake, n_wake;
    logic [trs_pkg::TIME_BITS-1:0]       r_now, n_now;
    logic [trs_pkg::TIMER_AW-1:0]        r_th, n_th;
    logic [trs_pkg::LEVEL_BITS-1:0]      r_tfill, n_tfill;
    logic [trs_pkg::READY_AW-1:0]        r_rh, n_rh;
    logic [trs_pkg::LEVEL_BITS-1:0]      r_rfill, n_rfill;
    logic [trs_pkg::TIME_BITS-1:0]       r_first, n_first;
    logic [trs_pkg::TASK_BITS-1:0]       r_first_task, n_first_task;
    logic [trs_pkg::LEVEL_BITS-1:0]      r_i, n_i;
    logic [trs_pkg::LEVEL_BITS-1:0]      r_k, n_k;
    logic                                r_chk, n_chk;
    logic                                r_from_check, n_from_check;
    logic [2:0]                          r_st, n_st;
    logic [trs_pkg::TASK_BITS-1:0]       r_rtask, n_rtask;
    logic                                r_last, n_last;
    logic                                r_ovalid, n_ovalid;
    trs_pkg::t_out_item                  r_odata, n_odata;

    logic                                t_we;
    logic [trs_pkg::TIMER_AW-1:0]        t_waddr, t_raddr;
    logic [trs_pkg::TENTRY_BITS-1:0]     t_wdata, t_rdata;
    logic                                q_we;
    logic [trs_pkg::READY_AW-1:0]        q_waddr, q_raddr;
    logic [trs_pkg::TASK_BITS-1:0]       q_wdata, q_rdata;
    logic                                dup;
    logic                                more_due;

    trs_ram #(.DEPTH(trs_pkg::TIMER_DEPTH), .WIDTH(trs_pkg::TENTRY_BITS)) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    trs_ram #(.DEPTH(trs_pkg::READY_DEPTH), .WIDTH(trs_pkg::TASK_BITS)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign i_req.ready = (r_state == trs_pkg::S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= trs_pkg::S_IDLE;
            r_th     <= '0;
            r_tfill  <= '0;
            r_rh     <= '0;
            r_rfill  <= '0;
            r_chk    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_th     <= n_th;
            r_tfill  <= n_tfill;
            r_rh     <= n_rh;
            r_rfill  <= n_rfill;
            r_chk    <= n_chk;
            r_ovalid <= n_ovalid;
        end
        r_task       <= n_task;
        r_wake       <= n_wake;
        r_now        <= n_now;
        r_first      <= n_first;
        r_first_task <= n_first_task;
        r_i          <= n_i;
        r_k          <= n_k;
        r_from_check <= n_from_check;
        r_st         <= n_st;
        r_rtask      <= n_rtask;
        r_last       <= n_last;
        r_odata      <= n_odata;
    end

    always_comb begin
        n_state      = r_state;
        n_task       = r_task;
        n_wake       = r_wake;
        n_now        = r_now;
        n_th         = r_th;
        n_tfill      = r_tfill;
        n_rh         = r_rh;
        n_rfill      = r_rfill;
        n_first      = r_first;
        n_first_task = r_first_task;
        n_i          = r_i;
        n_k          = r_k;
        n_chk        = r_chk;
        n_from_check = r_from_check;
        n_st         = r_st;
        n_rtask      = r_rtask;
        n_last       = r_last;
        n_odata      = r_odata;
        n_ovalid     = r_ovalid && !o_rsp.ready;
        t_we         = 1'b0;
        t_waddr      = '0;
        t_wdata      = '0;
        t_raddr      = '0;
        q_we         = 1'b0;
        q_waddr      = '0;
        q_wdata      = '0;
        q_raddr      = '0;
        dup          = r_chk && (q_rdata == r_task);
        more_due     = (r_tfill != '0) && (r_first <= r_now);

        case (r_state)
            trs_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_task       = i_req.data.task_id;
                    n_wake       = i_req.data.due_time;
                    n_now        = i_req.data.now;
                    n_rtask      = '0;
                    n_last       = 1'b1;
                    n_from_check = 1'b0;
                    n_k          = '0;
                    n_chk        = 1'b0;
                    case (i_req.data.operation)
                        trs_pkg::OP_ADD_READY: begin
                            if (i_req.data.finished) begin
                                n_st    = trs_pkg::ST_FIN;
                                n_state = trs_pkg::S_EMIT;
                            end else begin
                                n_state = trs_pkg::S_SCAN;
                            end
                        end
                        trs_pkg::OP_ADD_TIMER: begin
                            if (r_tfill == trs_pkg::LEVEL_BITS'(trs_pkg::TIMER_DEPTH)) begin
                                n_st    = trs_pkg::ST_FULL;
                                n_state = trs_pkg::S_EMIT;
                            end else begin
                                n_i     = r_tfill;
                                n_state = trs_pkg::S_INS;
                            end
                        end
                        trs_pkg::OP_CHECK: begin
                            n_state = trs_pkg::S_CHK;
                        end
                        default: begin
                            if (r_rfill == '0) begin
                                n_st    = trs_pkg::ST_NONE;
                                n_state = trs_pkg::S_EMIT;
                            end else begin
                                q_raddr = r_rh;
                                n_state = trs_pkg::S_DEQ;
                            end
                        end
                    endcase
                end
            end
            trs_pkg::S_INS: begin
                if (r_i == '0) begin
                    t_we         = 1'b1;
                    t_waddr      = r_th;
                    t_wdata      = {r_wake, r_task};
                    n_first      = r_wake;
                    n_first_task = r_task;
                    n_tfill      = r_tfill + 1'b1;
                    n_st         = trs_pkg::ST_OK;
                    n_state      = trs_pkg::S_EMIT;
                end else begin
                    t_raddr = r_th + r_i[trs_pkg::TIMER_AW-1:0] - 1'b1;
                    n_state = trs_pkg::S_INS_CHK;
                end
            end
            trs_pkg::S_INS_CHK: begin
                t_we    = 1'b1;
                t_waddr = r_th + r_i[trs_pkg::TIMER_AW-1:0];
                if (t_rdata[trs_pkg::TENTRY_BITS-1:trs_pkg::TASK_BITS] > r_wake) begin
                    t_wdata = t_rdata;
                    n_i     = r_i - 1'b1;
                    n_state = trs_pkg::S_INS;
                end else begin
                    t_wdata = {r_wake, r_task};
                    n_tfill = r_tfill + 1'b1;
                    n_st    = trs_pkg::ST_OK;
                    n_state = trs_pkg::S_EMIT;
                end
            end
            trs_pkg::S_CHK: begin
                if (more_due) begin
                    n_task       = r_first_task;
                    n_th         = r_th + 1'b1;
                    n_tfill      = r_tfill - 1'b1;
                    t_raddr      = r_th + 1'b1;
                    n_from_check = 1'b1;
                    n_k          = '0;
                    n_chk        = 1'b0;
                    n_state      = trs_pkg::S_LOADF;
                end else begin
                    n_st    = trs_pkg::ST_NONE;
                    n_rtask = '0;
                    n_last  = 1'b1;
                    n_state = trs_pkg::S_EMIT;
                end
            end
            trs_pkg::S_LOADF: begin
                n_first      = t_rdata[trs_pkg::TENTRY_BITS-1:trs_pkg::TASK_BITS];
                n_first_task = t_rdata[trs_pkg::TASK_BITS-1:0];
                n_state      = trs_pkg::S_SCAN;
            end
            trs_pkg::S_SCAN: begin
                n_chk   = 1'b0;
                n_rtask = r_from_check ? r_task : '0;
                n_last  = r_from_check ? !more_due : 1'b1;
                if (dup) begin
                    n_st    = trs_pkg::ST_DUP;
                    n_state = trs_pkg::S_EMIT;
                end else if (r_k < r_rfill) begin
                    q_raddr = r_rh + r_k[trs_pkg::READY_AW-1:0];
                    n_k     = r_k + 1'b1;
                    n_chk   = 1'b1;
                end else if (r_rfill == trs_pkg::LEVEL_BITS'(trs_pkg::READY_DEPTH)) begin
                    n_st    = r_from_check ? trs_pkg::ST_XDROP : trs_pkg::ST_FULL;
                    n_state = trs_pkg::S_EMIT;
                end else begin
                    q_we    = 1'b1;
                    q_waddr = r_rh + r_rfill[trs_pkg::READY_AW-1:0];
                    q_wdata = r_task;
                    n_rfill = r_rfill + 1'b1;
                    n_st    = r_from_check ? trs_pkg::ST_MOVED : trs_pkg::ST_OK;
                    n_state = trs_pkg::S_EMIT;
                end
            end
            trs_pkg::S_DEQ: begin
                n_rtask = q_rdata;
                n_rh    = r_rh + 1'b1;
                n_rfill = r_rfill - 1'b1;
                n_st    = trs_pkg::ST_OK;
                n_state = trs_pkg::S_EMIT;
            end
            trs_pkg::S_EMIT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid            = 1'b1;
                    n_odata.status      = r_st;
                    n_odata.result_task = r_rtask;
                    n_odata.ready_level = r_rfill;
                    n_odata.timer_level = r_tfill;
                    n_odata.next_wake   = (r_tfill == '0) ? '1 : r_first;
                    n_odata.last        = r_last;
                    n_state             = r_last ? trs_pkg::S_IDLE : trs_pkg::S_CHK;
                end
            end
            default: begin
                n_state = trs_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
